// ===== hw/rtl/sdspi_pkg.sv =====
`default_nettype none
package sdspi_pkg;

  // Field widths
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned ARG_W    = 32;
  localparam int unsigned RTYPE_W  = 2;
  localparam int unsigned RESP_W   = 16;
  localparam int unsigned FRAME_W  = 48;
  localparam int unsigned COUNT_W  = 6;

  localparam int unsigned GAP_CLOCKS_DEF = 8;

  // Item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Response types (zero behaves as R1)
  localparam logic [RTYPE_W-1:0] RESP_R1  = 2'd1;
  localparam logic [RTYPE_W-1:0] RESP_R1B = 2'd2;
  localparam logic [RTYPE_W-1:0] RESP_R2  = 2'd3;

  // Frame bytes
  localparam logic [7:0] START_BITS = 8'h40;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_DUMMY  = 8'hFF;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] R1_HIGH    = 8'hFF;

  // Bit counts per phase (last count value)
  localparam logic [COUNT_W-1:0] SEND_LAST = 6'd47;
  localparam logic [COUNT_W-1:0] BYTE_LAST = 6'd7;
  localparam logic [COUNT_W-1:0] R2_LAST   = 6'd15;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_SEND = 7'b0000010,
    PH_GAP  = 7'b0000100,
    PH_R1   = 7'b0001000,
    PH_BUSY = 7'b0010000,
    PH_R2   = 7'b0100000,
    PH_TAIL = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] cmd_index;
    logic [ARG_W-1:0]   cmd_arg;
    logic [RTYPE_W-1:0] resp_type;
    logic               keep_selected;
    logic               miso_bit;
  } cmd_item_t;

  typedef struct packed {
    logic              clock_pulse;
    logic              mosi;
    logic              select_n;
    logic              active;
    logic              done_res;
    logic [RESP_W-1:0] response;
  } res_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sdspi_stream_if.sv =====
`default_nettype none
interface sdspi_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sd_spi_command_engine.sv =====
// Each accepted item's result item is registered in the output register.
// Throughput: 1 item per cycle; a tick item gives an SCLK pulse only while a command runs, a start item none.
// The output register refills in the cycle it is drained, so the engine stalls
// only while a result waits untaken.
// Reset (rst, synchronous, active high): engine idle, select released,
// output register empty.
`default_nettype none
module sd_spi_command_engine #(
  parameter int unsigned GAP_CLOCKS = sdspi_pkg::GAP_CLOCKS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  sdspi_stream_if.sink   cmd,
  sdspi_stream_if.source res
);

  // Last count of the gap and tail phases
  localparam logic [sdspi_pkg::COUNT_W-1:0] GAP_LAST =
    sdspi_pkg::COUNT_W'(GAP_CLOCKS - 1);

  // Engine state
  sdspi_pkg::phase_t                  phase, phase_next;
  logic [sdspi_pkg::COUNT_W-1:0]      bit_count, bit_count_next;
  logic [sdspi_pkg::FRAME_W-1:0]      frame_shift, frame_shift_next;
  logic [sdspi_pkg::RESP_W-1:0]       receive_shift, receive_shift_next;
  logic [sdspi_pkg::RTYPE_W-1:0]      latched_resp_type, latched_resp_type_next;
  logic                               latched_keep, latched_keep_next;
  logic                               select_level, select_level_next;

  // Output register
  logic                  res_valid;
  sdspi_pkg::res_item_t  res_data, res_data_next;

  logic accept;
  logic last_bit;
  logic [7:0] byte_shift;
  logic [7:0] busy_shift;
  logic [sdspi_pkg::RESP_W-1:0] r2_shift;
  logic [7:0] crc_byte;
  logic clk_pulse, mosi_bit, done, finish;
  logic [sdspi_pkg::RESP_W-1:0] finish_value;

  // Take a new item whenever the result slot is empty or being drained
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign res.valid = res_valid;
  assign res.data  = res_data;

  // Shift candidates for the receive phases
  assign byte_shift = {receive_shift[6:0], cmd.data.miso_bit};
  assign busy_shift = {receive_shift[6:0], cmd.data.miso_bit};
  assign r2_shift   = {receive_shift[sdspi_pkg::RESP_W-2:0], cmd.data.miso_bit};
  assign crc_byte   = (cmd.data.cmd_index == '0) ? sdspi_pkg::CRC_CMD0
                                                 : sdspi_pkg::CRC_DUMMY;

  always_comb begin
    phase_next             = phase;
    bit_count_next         = bit_count;
    frame_shift_next       = frame_shift;
    receive_shift_next     = receive_shift;
    latched_resp_type_next = latched_resp_type;
    latched_keep_next      = latched_keep;
    select_level_next      = select_level;
    clk_pulse              = 1'b0;
    mosi_bit               = 1'b1;
    done                   = 1'b0;
    finish                 = 1'b0;
    finish_value           = '0;
    last_bit               = 1'b0;

    if (cmd.data.command == sdspi_pkg::CMD_START) begin
      // Start abandons anything in flight
      frame_shift_next       = {sdspi_pkg::START_BITS | {2'b00, cmd.data.cmd_index},
                                cmd.data.cmd_arg, crc_byte};
      latched_resp_type_next = cmd.data.resp_type;
      latched_keep_next      = cmd.data.keep_selected;
      receive_shift_next     = '0;
      bit_count_next         = '0;
      select_level_next      = 1'b0;
      phase_next             = sdspi_pkg::PH_SEND;
    end else if (phase != sdspi_pkg::PH_IDLE) begin
      clk_pulse      = 1'b1;
      bit_count_next = bit_count + 1'b1;
      case (phase)
        sdspi_pkg::PH_SEND: begin
          mosi_bit         = frame_shift[sdspi_pkg::FRAME_W-1];
          frame_shift_next = {frame_shift[sdspi_pkg::FRAME_W-2:0], 1'b0};
          if (bit_count == sdspi_pkg::SEND_LAST) begin
            bit_count_next = '0;
            phase_next     = sdspi_pkg::PH_GAP;
          end
        end
        sdspi_pkg::PH_GAP: begin
          if (bit_count == GAP_LAST) begin
            bit_count_next     = '0;
            receive_shift_next = '0;
            phase_next = (latched_resp_type == sdspi_pkg::RESP_R2) ? sdspi_pkg::PH_R2
                                                                   : sdspi_pkg::PH_R1;
          end
        end
        sdspi_pkg::PH_R1: begin
          receive_shift_next = {8'h00, byte_shift};
          last_bit           = (bit_count == sdspi_pkg::BYTE_LAST);
          if (last_bit) begin
            bit_count_next = '0;
            if (byte_shift != sdspi_pkg::BYTE_IDLE) begin
              if (latched_resp_type == sdspi_pkg::RESP_R1B) begin
                receive_shift_next = {byte_shift, 8'h00};
                phase_next         = sdspi_pkg::PH_BUSY;
              end else begin
                finish       = 1'b1;
                finish_value = {sdspi_pkg::R1_HIGH, byte_shift};
              end
            end else begin
              receive_shift_next = '0;
            end
          end
        end
        sdspi_pkg::PH_BUSY: begin
          // High byte keeps the R1 byte, low byte collects busy bits
          receive_shift_next = {receive_shift[15:8], busy_shift};
          last_bit           = (bit_count == sdspi_pkg::BYTE_LAST);
          if (last_bit) begin
            bit_count_next = '0;
            if (busy_shift != 8'h00) begin
              finish       = 1'b1;
              finish_value = {sdspi_pkg::R1_HIGH, receive_shift[15:8]};
            end else begin
              receive_shift_next = {receive_shift[15:8], 8'h00};
            end
          end
        end
        sdspi_pkg::PH_R2: begin
          receive_shift_next = r2_shift;
          if (bit_count == sdspi_pkg::R2_LAST) begin
            finish       = 1'b1;
            finish_value = r2_shift;
          end
        end
        default: begin
          // Tail clocks, then report
          if (bit_count == GAP_LAST || phase != sdspi_pkg::PH_TAIL) begin
            bit_count_next = '0;
            done           = 1'b1;
            phase_next     = sdspi_pkg::PH_IDLE;
          end
        end
      endcase

      if (finish) begin
        receive_shift_next = finish_value;
        if (!latched_keep) begin
          select_level_next = 1'b1;
        end
        phase_next     = sdspi_pkg::PH_TAIL;
        bit_count_next = '0;
      end
    end

    res_data_next.clock_pulse = clk_pulse;
    res_data_next.mosi        = mosi_bit;
    res_data_next.select_n    = select_level_next;
    res_data_next.active      = (phase_next != sdspi_pkg::PH_IDLE);
    res_data_next.done_res    = done;
    res_data_next.response    = done ? receive_shift : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sdspi_pkg::PH_IDLE;
      bit_count         <= '0;
      frame_shift       <= '0;
      receive_shift     <= '0;
      latched_resp_type <= sdspi_pkg::RESP_R1;
      latched_keep      <= 1'b0;
      select_level      <= 1'b1;
      res_valid         <= 1'b0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        bit_count         <= bit_count_next;
        frame_shift       <= frame_shift_next;
        receive_shift     <= receive_shift_next;
        latched_resp_type <= latched_resp_type_next;
        latched_keep      <= latched_keep_next;
        select_level      <= select_level_next;
        res_valid         <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_data_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_sd_spi_command_engine.sv =====
module tb_sd_spi_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  localparam int unsigned GAP_TICKS = GAP_CLOCKS_DEF;
  // Tick budget large enough for any transaction the card model lets finish.
  localparam int RUN_TO_END = 1000;
  // Rough number of items per random phase.
  localparam int PHASE_ITEMS = 140;

  logic clk;
  logic rst;

  sdspi_stream_if #(.item_t(cmd_item_t)) cmd_if ();
  sdspi_stream_if #(.item_t(res_item_t)) res_if ();

  sd_spi_command_engine #(
    .GAP_CLOCKS(GAP_TICKS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  res_item_t bus_results_due[$];  // expected result items, oldest first
  logic      card_bits[$];        // bits the card drives on MISO, in order
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        send_idle_pct  = 0;  // chance in 100 that the sender skips a cycle
  int        recv_idle_pct  = 0;  // chance in 100 that the receiver stalls
  int        hold_cycles    = 0;  // receiver hold-off, counted down per cycle

  // Predictor copy of the engine state.
  phase_t             eng_phase;
  int                 eng_count;
  logic [FRAME_W-1:0] eng_frame;
  logic [RESP_W-1:0]  eng_rx;
  logic [RTYPE_W-1:0] eng_rtype;
  logic               eng_keep;
  logic               eng_sel;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("** sd_spi_command_engine: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Response complete: latch it, drop select unless kept, start the tail clocks.
  function automatic void close_response(input logic [RESP_W-1:0] value);
    eng_rx = value;
    if (!eng_keep) eng_sel = 1'b1;
    eng_phase = PH_TAIL;
    eng_count = 0;
  endfunction

  // One item through the engine; returns the result item it must produce.
  function automatic res_item_t engine_step(input cmd_item_t it);
    res_item_t r;
    r = '0;
    r.mosi = 1'b1;
    if (it.command == CMD_START) begin
      // A start always restarts, even in the middle of a transaction.
      eng_frame = {START_BITS | {2'b00, it.cmd_index}, it.cmd_arg,
                   (it.cmd_index == '0) ? CRC_CMD0 : CRC_DUMMY};
      eng_rtype = it.resp_type;
      eng_keep  = it.keep_selected;
      eng_rx    = '0;
      eng_count = 0;
      eng_sel   = 1'b0;
      eng_phase = PH_SEND;
    end else if (eng_phase != PH_IDLE) begin
      r.clock_pulse = 1'b1;
      case (eng_phase)
        PH_SEND: begin
          r.mosi    = eng_frame[FRAME_W-1];
          eng_frame = eng_frame << 1;
          eng_count++;
          if (eng_count >= FRAME_W) begin
            eng_count = 0;
            eng_phase = PH_GAP;
          end
        end
        PH_GAP: begin
          eng_count++;
          if (eng_count >= GAP_TICKS) begin
            eng_count = 0;
            eng_rx    = '0;
            // type 0 falls through to R1
            eng_phase = (eng_rtype == RESP_R2) ? PH_R2 : PH_R1;
          end
        end
        PH_R1: begin
          eng_rx = {8'h00, eng_rx[6:0], it.miso_bit};
          eng_count++;
          if (eng_count >= 8) begin
            eng_count = 0;
            if (eng_rx[7:0] != BYTE_IDLE) begin
              if (eng_rtype == RESP_R1B) begin
                eng_rx    = {eng_rx[7:0], 8'h00};
                eng_phase = PH_BUSY;
              end else begin
                close_response({R1_HIGH, eng_rx[7:0]});
              end
            end else begin
              eng_rx = '0;
            end
          end
        end
        PH_BUSY: begin
          // R1 byte held in the upper half; busy ends on a non-zero byte
          eng_rx[7:0] = {eng_rx[6:0], it.miso_bit};
          eng_count++;
          if (eng_count >= 8) begin
            eng_count = 0;
            if (eng_rx[7:0] != 8'h00) close_response({R1_HIGH, eng_rx[15:8]});
            else eng_rx[7:0] = 8'h00;
          end
        end
        PH_R2: begin
          eng_rx = {eng_rx[RESP_W-2:0], it.miso_bit};
          eng_count++;
          if (eng_count >= RESP_W) close_response(eng_rx);
        end
        default: begin
          // tail clocks; the response leaves on the last one
          eng_count++;
          if (eng_count >= GAP_TICKS) begin
            eng_count     = 0;
            r.done_res    = 1'b1;
            r.response    = eng_rx;
            eng_phase     = PH_IDLE;
          end
        end
      endcase
    end
    r.select_n = eng_sel;
    r.active   = (eng_phase != PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and prediction, both on the rising edge
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [RESP_W-1:0] exp_v,
                                      input logic [RESP_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_items
    res_item_t due;
    res_item_t got;
    if (!rst) begin
      // Result first: it belongs to an item accepted at an earlier edge.
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (bus_results_due.size() == 0) begin
          $error("result item with none expected: 0x%0h", got);
          mismatch_count++;
        end else begin
          due = bus_results_due.pop_front();
          check_field("clock_pulse", due.clock_pulse, got.clock_pulse);
          check_field("mosi", due.mosi, got.mosi);
          check_field("select_n", due.select_n, got.select_n);
          check_field("active", due.active, got.active);
          check_field("done_res", due.done_res, got.done_res);
          check_field("response", due.response, got.response);
        end
      end
      if (cmd_if.valid && cmd_if.ready) bus_results_due.push_back(engine_step(cmd_if.data));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no extra assignment.
  task automatic send_item(input cmd_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Tick item; fields the engine ignores on a tick carry noise.
  function automatic cmd_item_t tick_item(input logic miso);
    cmd_item_t it;
    it.command       = CMD_TICK;
    it.cmd_index     = INDEX_W'($urandom);
    it.cmd_arg       = ARG_W'($urandom);
    it.resp_type     = RTYPE_W'($urandom);
    it.keep_selected = 1'($urandom);
    it.miso_bit      = miso;
    return it;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) card_bits.push_back(b[i]);
  endtask

  // Start a command and clock it until it ends or tick_limit runs out.
  // MISO follows card_bits while the engine listens, idles high once the
  // card has nothing left, and is noise while the frame goes out.
  task automatic run_command(input logic [INDEX_W-1:0] idx, input logic [ARG_W-1:0] arg,
                             input logic [RTYPE_W-1:0] rtype, input logic keep,
                             input int tick_limit);
    cmd_item_t it;
    int        n;
    it.command       = CMD_START;
    it.cmd_index     = idx;
    it.cmd_arg       = arg;
    it.resp_type     = rtype;
    it.keep_selected = keep;
    it.miso_bit      = 1'($urandom);
    send_item(it);
    n = 0;
    while (eng_phase != PH_IDLE && n < tick_limit) begin
      it = tick_item(1'($urandom));
      if (eng_phase inside {PH_R1, PH_BUSY, PH_R2})
        it.miso_bit = (card_bits.size() != 0) ? card_bits.pop_front() : 1'b1;
      send_item(it);
      n++;
    end
    card_bits.delete();
  endtask

  task automatic idle_ticks(input int count);
    repeat (count) send_item(tick_item(1'($urandom)));
  endtask

  // Stop offering until every expected result is back.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random command with a mostly well-formed card reply.
  task automatic random_command();
    logic [RTYPE_W-1:0] rtype;
    logic [ARG_W-1:0]   arg;
    logic [INDEX_W-1:0] idx;
    int                 limit;
    int                 pick;
    rtype = RTYPE_W'($urandom_range(0, 3));
    pick  = int'($urandom_range(0, 9));
    arg   = (pick == 0) ? '0 : (pick == 1) ? '1 : ARG_W'($urandom);
    idx   = ($urandom_range(0, 3) == 0) ? '0 : INDEX_W'($urandom_range(0, 63));
    limit = RUN_TO_END;
    pick  = int'($urandom_range(0, 11));
    if (pick == 0) begin
      // silent card: R1 and busy never end, cut off and left running
      limit = int'($urandom_range(60, 160));
      if (rtype == RESP_R1B) begin
        push_byte(8'h00);
        repeat (12) push_byte(8'h00);
      end
    end else begin
      if (rtype == RESP_R2) begin
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) push_byte(BYTE_IDLE);
        push_byte(8'($urandom_range(0, 254)));
        if (rtype == RESP_R1B) begin
          repeat ($urandom_range(0, 3)) push_byte(8'h00);
          push_byte(8'($urandom_range(1, 255)));
        end
      end
      // broken sequence: the next start arrives mid-transaction
      if (pick == 1) limit = int'($urandom_range(1, 90));
    end
    run_command(idx, arg, rtype, 1'($urandom), limit);
    idle_ticks(int'($urandom_range(0, 3)));
  endtask

  task automatic random_phase(input int sender_pct, input int receiver_pct);
    int start_count;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start_count   = items_sent;
    while (items_sent - start_count < PHASE_ITEMS) random_command();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Ticks with nothing running: no clock, MOSI high, select released.
  task automatic test_idle_ticks();
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));
  endtask

  // CMD0 with its real CRC; card answers after two idle bytes.
  task automatic test_cmd0_reply();
    push_byte(BYTE_IDLE);
    push_byte(BYTE_IDLE);
    push_byte(8'h01);
    run_command('0, '0, RESP_R1, 1'b0, RUN_TO_END);
  endtask

  // Highest index, all-ones argument, R1b kept selected: busy ends on the
  // first non-zero byte; select stays low through the idle ticks after it.
  task automatic test_busy_kept();
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h80);
    run_command('1, '1, RESP_R1B, 1'b1, RUN_TO_END);
    idle_ticks(3);
  endtask

  // R2 sixteen bits, releases the select held by the previous command.
  task automatic test_r2_word();
    push_byte(8'h80);
    push_byte(8'h01);
    run_command(6'd9, 32'hA5A5_5A5A, RESP_R2, 1'b0, RUN_TO_END);
    push_byte(8'h7F);
    push_byte(8'hFE);
    run_command(6'd13, 32'h0000_0001, RESP_R2, 1'b1, RUN_TO_END);
  endtask

  // Response type zero behaves as R1.
  task automatic test_type_zero();
    push_byte(8'hFE);
    run_command(6'd17, 32'h8000_0000, 2'd0, 1'b0, RUN_TO_END);
  endtask

  // Start while a command runs: abandon it, begin again from the first bit.
  task automatic test_restart();
    run_command(6'd8, 32'h0000_01AA, RESP_R1, 1'b1, 20);
    push_byte(8'hFF);
    push_byte(8'h05);
    push_byte(8'h00);
    push_byte(8'h01);
    run_command(6'd1, 32'h4000_0000, RESP_R1B, 1'b0, 70);
    push_byte(8'h00);
    run_command(6'd55, 32'h1234_5678, RESP_R1, 1'b0, RUN_TO_END);
  endtask

  // Card never answers, then never leaves busy: engine keeps clocking.
  task automatic test_silent_card();
    run_command(6'd41, 32'h4000_0000, RESP_R1, 1'b0, 140);
    push_byte(8'h00);
    repeat (10) push_byte(8'h00);
    run_command(6'd12, 32'h0, RESP_R1B, 1'b1, 150);
    push_byte(8'h3C);
    run_command(6'd16, 32'h0000_0200, RESP_R1, 1'b0, RUN_TO_END);
  endtask

  // Receiver holds off while the sender keeps offering; then a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 10;
    hold_cycles   = 300;
    random_command();
    random_command();
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    // predictor at its reset state
    eng_phase = PH_IDLE;
    eng_count = 0;
    eng_frame = '0;
    eng_rx    = '0;
    eng_rtype = RESP_R1;
    eng_keep  = 1'b0;
    eng_sel   = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 84;
    test_idle_ticks();
    test_cmd0_reply();
    test_busy_kept();
    test_r2_word();
    test_type_zero();
    test_restart();
    test_silent_card();
    test_backpressure();

    random_phase(14, 84);
    random_phase(84, 14);
    random_phase(0, 0);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && bus_results_due.size() == 0) begin
      $display("** sd_spi_command_engine: PASSED **");
    end else begin
      $display("** sd_spi_command_engine: FAILED **");
    end
    $finish;
  end

endmodule
